@@ src/odq_pkg.sv @@
// Shared types, constants and register codes for the ordered dither quantizer.
package odq_pkg;

    localparam int PATTERN_DEPTH = 256;
    localparam int IDX_W         = $clog2(PATTERN_DEPTH);

    localparam int COL_W     = 16;
    localparam int SAMPLE_W  = 16;
    localparam int ENTRY_W   = 8;
    localparam int DITHER_W  = 18;
    localparam int SCALE_W   = 24;
    localparam int BIAS_W    = 32;
    localparam int BITS_W    = 5;
    localparam int PIXEL_W   = 16;
    localparam int PROD_W    = SAMPLE_W + SCALE_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_W    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE         = 3'd0,
        REG_BIAS          = 3'd1,
        REG_OUT_BITS      = 3'd2,
        REG_PATTERN_START = 3'd3,
        REG_PATTERN_MASK  = 3'd4
    } cfg_reg_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic                       wr_en;
        logic [IDX_W-1:0]           wr_addr;
        logic signed [DITHER_W-1:0] wr_data;
        logic                       rd_en;
        logic [IDX_W-1:0]           rd_addr;
    } mem_req_t;

endpackage

@@ src/odq_pattern_mem.sv @@
// Dither pattern memory with one write port and one registered read port.
module odq_pattern_mem
    import odq_pkg::*;
(
    input  logic                       aclk,
    input  mem_req_t                   req,
    output logic signed [DITHER_W-1:0] rd_data
);

    logic signed [DITHER_W-1:0] mem [PATTERN_DEPTH];
    logic signed [DITHER_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/odq_round_clamp.sv @@
// Sum of product, bias and dither, rounded half to even and clamped to the output depth.
module odq_round_clamp
    import odq_pkg::*;
(
    input  logic [PROD_W-1:0]          prod,
    input  logic signed [BIAS_W-1:0]   bias,
    input  logic signed [DITHER_W-1:0] dither,
    input  logic [BITS_W-1:0]          out_bits,
    output logic [PIXEL_W-1:0]         pixel
);

    localparam int Q_W = SUM_W - FRAC_W;

    logic signed [SUM_W-1:0] sum;
    logic                    positive;
    logic [FRAC_W-1:0]       frac;
    logic [Q_W-2:0]          q_base;
    logic                    round_up;
    logic [Q_W-1:0]          q_rnd;
    logic [BITS_W-1:0]       bits;
    logic [PIXEL_W-1:0]      maxv;

    always_comb begin
        sum      = signed'({2'b00, prod}) + SUM_W'(bias) + SUM_W'(dither);
        positive = !sum[SUM_W-1] && (sum != '0);
        frac     = sum[FRAC_W-1:0];
        q_base   = sum[SUM_W-2:FRAC_W];
        round_up = (frac > 16'h8000) || ((frac == 16'h8000) && q_base[0]);
        q_rnd    = {1'b0, q_base} + Q_W'(round_up);
        bits     = (out_bits > BITS_W'(PIXEL_W)) ? BITS_W'(PIXEL_W) : out_bits;
        maxv     = PIXEL_W'(((PIXEL_W + 1)'(1) << bits) - (PIXEL_W + 1)'(1));
        if (!positive) begin
            pixel = '0;
        end else if (q_rnd > Q_W'(maxv)) begin
            pixel = maxv;
        end else begin
            pixel = q_rnd[PIXEL_W-1:0];
        end
    end

endmodule

@@ src/ordered_dither_quantizer.sv @@
// Top level of the ordered dither quantizer: handshakes, configuration and pipeline.
//
// The block takes one beat per clock cycle while the output is not stalled; each pixel
// result passes through registered stages: the first stage multiplies the sample by the
// gain and reads the dither entry from the pattern memory, the second adds, rounds,
// clamps and loads the output register. Pattern writes use the same input channel and
// give no result; a pixel that follows a write in the next cycle already sees the
// new entry. The pattern memory holds PATTERN_DEPTH entries, a power of two, and is not
// cleared, so every entry a pixel can reach must be written first. Configuration writes
// are always accepted and must only be issued while no pixel is in flight.
module ordered_dither_quantizer
    import odq_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [COL_W-1:0]           s_column,
    input  logic [SAMPLE_W-1:0]        s_sample,
    input  logic                       s_row_end,
    input  logic [ENTRY_W-1:0]         s_entry_index,
    input  logic signed [DITHER_W-1:0] s_entry_value,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [PIXEL_W-1:0]         m_pixel_out,
    output logic                       m_row_end_out
);

    logic [SCALE_W-1:0]       scale_reg;
    logic signed [BIAS_W-1:0] bias_reg;
    logic [BITS_W-1:0]        out_bits_reg;
    logic [7:0]               pattern_start_reg;
    logic [7:0]               pattern_mask_reg;

    logic                       advance;
    logic                       in_beat;
    logic                       stage_valid_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       stage_row_end_reg;
    logic signed [DITHER_W-1:0] dither;
    logic [COL_W-1:0]           pattern_pos;
    mem_req_t                   mem_req;
    logic [PIXEL_W-1:0]         pixel_next;
    logic                       m_valid_reg;
    logic [PIXEL_W-1:0]         m_pixel_reg;
    logic                       m_row_end_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg         <= SCALE_W'(65536);
            bias_reg          <= '0;
            out_bits_reg      <= BITS_W'(8);
            pattern_start_reg <= '0;
            pattern_mask_reg  <= 8'hFF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SCALE:         scale_reg         <= cfg_data[SCALE_W-1:0];
                REG_BIAS:          bias_reg          <= signed'(cfg_data);
                REG_OUT_BITS:      out_bits_reg      <= cfg_data[BITS_W-1:0];
                REG_PATTERN_START: pattern_start_reg <= cfg_data[7:0];
                REG_PATTERN_MASK:  pattern_mask_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign in_beat = s_valid && s_ready;

    assign pattern_pos = (COL_W'(pattern_start_reg) + s_column) & COL_W'(pattern_mask_reg);

    always_comb begin
        mem_req.wr_en   = in_beat && (s_op == OP_WRITE);
        mem_req.wr_addr = IDX_W'(s_entry_index);
        mem_req.wr_data = s_entry_value;
        mem_req.rd_en   = in_beat && (s_op == OP_PIXEL);
        mem_req.rd_addr = pattern_pos[IDX_W-1:0];
    end

    odq_pattern_mem u_pattern_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (dither)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (advance) begin
            stage_valid_reg <= in_beat && (s_op == OP_PIXEL);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && (s_op == OP_PIXEL)) begin
            prod_reg          <= PROD_W'(s_sample) * PROD_W'(scale_reg);
            stage_row_end_reg <= s_row_end;
        end
    end

    odq_round_clamp u_round_clamp (
        .prod     (prod_reg),
        .bias     (bias_reg),
        .dither   (dither),
        .out_bits (out_bits_reg),
        .pixel    (pixel_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && stage_valid_reg) begin
            m_pixel_reg   <= pixel_next;
            m_row_end_reg <= stage_row_end_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_out   = m_pixel_reg;
    assign m_row_end_out = m_row_end_reg;

    // A pattern write must never create a pixel in the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && (s_op == OP_WRITE)) |=> !stage_valid_reg)
        else $error("pattern write produced a pipeline entry");

    // An accepted pixel always enters the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && (s_op == OP_PIXEL)) |=> stage_valid_reg)
        else $error("accepted pixel was lost at the first stage");

    // A first-stage pixel moves to the output when the pipeline advances.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && advance) |=> m_valid_reg)
        else $error("pixel lost between first stage and output");

    // While a result is stalled, the first stage keeps its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && !advance) |=> stage_valid_reg)
        else $error("first stage dropped an item during a stall");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid_reg)
        else $error("result pending after reset");

endmodule

@@ dv/odq_monitor.sv @@
// Channel monitor for the ordered dither quantizer: predicts each pixel result and compares.
`timescale 1ns / 1ps

module odq_monitor
    import odq_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_op,
    input  logic [COL_W-1:0]           s_column,
    input  logic [SAMPLE_W-1:0]        s_sample,
    input  logic                       s_row_end,
    input  logic [ENTRY_W-1:0]         s_entry_index,
    input  logic signed [DITHER_W-1:0] s_entry_value,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [PIXEL_W-1:0]         m_pixel_out,
    input  logic                       m_row_end_out,

    output int                         fail_count,
    output int                         outstanding
);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
    } quant_result_t;

    quant_result_t              pixels_due[$];

    logic [SCALE_W-1:0]         gain        = 24'd65536;
    logic signed [BIAS_W-1:0]   offset      = '0;
    logic [BITS_W-1:0]          depth       = 5'd8;
    logic [ENTRY_W-1:0]         phase_start = '0;
    logic [ENTRY_W-1:0]         phase_mask  = 8'hFF;
    logic signed [DITHER_W-1:0] pattern [PATTERN_DEPTH];

    task automatic report(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [PIXEL_W-1:0] quantize(input logic [SAMPLE_W-1:0] smp,
                                                    input logic [COL_W-1:0] col);
        logic [ENTRY_W-1:0] slot;
        longint             acc;
        longint             whole;
        longint             ceiling;
        int                 width;
        slot = phase_start + col[ENTRY_W-1:0];
        slot = slot & phase_mask;
        acc = longint'(smp) * longint'(gain) + longint'(offset)
            + longint'(pattern[slot % PATTERN_DEPTH]);
        whole = 0;
        if (acc > 0) begin
            whole = acc >>> FRAC_W;
            if (acc[FRAC_W-1:0] > (1 << (FRAC_W - 1)) ||
                (acc[FRAC_W-1:0] == (1 << (FRAC_W - 1)) && whole[0])) begin
                whole++;
            end
        end
        width = (depth > PIXEL_W) ? PIXEL_W : int'(depth);
        ceiling = (longint'(1) << width) - 1;
        if (whole > ceiling) begin
            whole = ceiling;
        end
        return whole[PIXEL_W-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        quant_result_t want;
        if (!aresetn) begin
            gain        = 24'd65536;
            offset      = '0;
            depth       = 5'd8;
            phase_start = '0;
            phase_mask  = 8'hFF;
            pixels_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCALE:         gain        = cfg_data[SCALE_W-1:0];
                    REG_BIAS:          offset      = cfg_data;
                    REG_OUT_BITS:      depth       = cfg_data[BITS_W-1:0];
                    REG_PATTERN_START: phase_start = cfg_data[ENTRY_W-1:0];
                    REG_PATTERN_MASK:  phase_mask  = cfg_data[ENTRY_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    report($sformatf("result beat %0d with no pixel pending", m_pixel_out));
                end else begin
                    want = pixels_due.pop_front();
                    if (m_pixel_out !== want.pixel) begin
                        report($sformatf("pixel_out mismatch: got %0d, expected %0d",
                                         m_pixel_out, want.pixel));
                    end
                    if (m_row_end_out !== want.row_end) begin
                        report($sformatf("row_end_out mismatch: got %b, expected %b",
                                         m_row_end_out, want.row_end));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_op == OP_WRITE) begin
                    pattern[s_entry_index % PATTERN_DEPTH] = s_entry_value;
                end else begin
                    want.pixel   = quantize(s_sample, s_column);
                    want.row_end = s_row_end;
                    pixels_due.push_back(want);
                end
            end
        end
        outstanding <= pixels_due.size();
    end

endmodule

@@ dv/ordered_dither_quantizer_test.sv @@
// Top of the ordered dither quantizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ordered_dither_quantizer_test;
    import odq_pkg::*;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;

    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    logic                       s_valid;
    logic                       s_ready;
    logic                       s_op;
    logic [COL_W-1:0]           s_column;
    logic [SAMPLE_W-1:0]        s_sample;
    logic                       s_row_end;
    logic [ENTRY_W-1:0]         s_entry_index;
    logic signed [DITHER_W-1:0] s_entry_value;

    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [PIXEL_W-1:0]         m_pixel_out;
    logic                       m_row_end_out;

    int                         fail_count;
    int                         outstanding;
    logic                       calm = 1'b0;
    int                         stall_left = 0;

    logic [ENTRY_W-1:0]         cur_start = '0;
    logic [ENTRY_W-1:0]         cur_mask  = 8'hFF;
    bit                         written [PATTERN_DEPTH];

    ordered_dither_quantizer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_column      (s_column),
        .s_sample      (s_sample),
        .s_row_end     (s_row_end),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end_out (m_row_end_out)
    );

    odq_monitor u_monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_column      (s_column),
        .s_sample      (s_sample),
        .s_row_end     (s_row_end),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_row_end_out (m_row_end_out),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic signed [DITHER_W-1:0] rand_dither();
        return DITHER_W'($urandom_range(0, (1 << DITHER_W) - 1));
    endfunction

    // Holds the beat on the channel until the block takes it; valid is left high.
    task automatic send_beat(input logic op, input logic [COL_W-1:0] col,
                             input logic [SAMPLE_W-1:0] smp, input logic row_end,
                             input logic [ENTRY_W-1:0] idx,
                             input logic signed [DITHER_W-1:0] value);
        s_valid       <= 1'b1;
        s_op          <= op;
        s_column      <= col;
        s_sample      <= smp;
        s_row_end     <= row_end;
        s_entry_index <= idx;
        s_entry_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_WRITE) begin
            written[idx % PATTERN_DEPTH] = 1'b1;
        end
    endtask

    task automatic put_entry(input logic [ENTRY_W-1:0] idx,
                             input logic signed [DITHER_W-1:0] value);
        send_beat(OP_WRITE, COL_W'($urandom_range(0, 65535)),
                  SAMPLE_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), idx, value);
    endtask

    // Loads the dither entry first whenever the pixel would reach one never written.
    task automatic put_pixel(input logic [COL_W-1:0] col, input logic [SAMPLE_W-1:0] smp,
                             input logic row_end);
        logic [ENTRY_W-1:0] slot;
        slot = cur_start + col[ENTRY_W-1:0];
        slot = slot & cur_mask;
        if (!written[slot % PATTERN_DEPTH]) begin
            put_entry(slot, rand_dither());
        end
        send_beat(OP_PIXEL, col, smp, row_end, ENTRY_W'($urandom_range(0, 255)),
                  rand_dither());
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(input logic [SCALE_W-1:0] gain, input logic [BIAS_W-1:0] offs,
                             input logic [BITS_W-1:0] bits, input logic [ENTRY_W-1:0] start,
                             input logic [ENTRY_W-1:0] msk);
        drain();
        cfg_write(REG_SCALE, CFG_DATA_W'(gain));
        cfg_write(REG_BIAS, offs);
        cfg_write(REG_OUT_BITS, CFG_DATA_W'(bits));
        cfg_write(REG_PATTERN_START, CFG_DATA_W'(start));
        cfg_write(REG_PATTERN_MASK, CFG_DATA_W'(msk));
        cfg_valid <= 1'b0;
        cur_start = start;
        cur_mask  = msk;
        @(posedge aclk);
    endtask

    initial begin
        #5_000_000;
        $display("ordered_dither_quantizer_test NOT OK");
        $finish;
    end

    initial begin
        int                 phase;
        int                 n;
        logic [SAMPLE_W-1:0] smp;
        logic [SCALE_W-1:0] gain;
        logic [BIAS_W-1:0]  offs;
        logic [BITS_W-1:0]  bits;
        logic [ENTRY_W-1:0] msk;
        s_valid       = 1'b0;
        s_op          = OP_PIXEL;
        s_column      = '0;
        s_sample      = '0;
        s_row_end     = 1'b0;
        s_entry_index = '0;
        s_entry_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SCALE;
        cfg_data      = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(24'd65536, 32'd0, 5'd16, 8'd0, 8'd3);
        put_entry(8'd0, DITHER_W'(-131072));
        put_entry(8'd1, DITHER_W'(131071));
        put_entry(8'd2, '0);
        put_entry(8'd3, DITHER_W'(32768));
        put_pixel(16'd0, 16'd0, 1'b0);
        put_pixel(16'd1, 16'hFFFF, 1'b0);
        put_pixel(16'd3, 16'd2, 1'b0);
        put_pixel(16'd3, 16'd3, 1'b0);
        put_pixel(16'd2, 16'd255, 1'b1);
        put_pixel(16'hFFFF, 16'h8000, 1'b1);
        configure(24'hFFFFFF, 32'h7FFFFFFF, 5'd0, 8'd255, 8'd0);
        put_pixel(16'hFFFF, 16'hFFFF, 1'b1);
        put_pixel(16'd0, 16'd0, 1'b0);
        configure(24'd0, 32'h80000000, 5'd31, 8'd128, 8'd1);
        put_pixel(16'd0, 16'hFFFF, 1'b0);
        put_pixel(16'd1, 16'd1, 1'b1);
        configure(24'd65536, 32'h00008000, 5'd17, 8'd0, 8'd3);
        put_pixel(16'd2, 16'd1000, 1'b0);
        put_pixel(16'd2, 16'd1001, 1'b0);
        put_pixel(16'd1, 16'hFFFF, 1'b1);

        for (phase = 0; phase < 9; phase++) begin
            if (phase == 8) begin
                calm <= 1'b1;
            end
            case ($urandom_range(0, 3))
                0:       gain = 24'd65536;
                1:       gain = SCALE_W'($urandom_range(0, 24'hFFFFFF));
                2:       gain = SCALE_W'($urandom_range(24'h8000, 24'h28000));
                default: gain = SCALE_W'($urandom_range(0, 24'hFFFF));
            endcase
            case ($urandom_range(0, 3))
                0:       offs = '0;
                1:       offs = $urandom_range(0, 1 << 21) - (1 << 20);
                2:       offs = $urandom;
                default: offs = -$urandom_range(0, 1 << 24);
            endcase
            case ($urandom_range(0, 3))
                0:       bits = 5'd8;
                1:       bits = 5'd16;
                2:       bits = BITS_W'($urandom_range(0, 31));
                default: bits = BITS_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 3))
                0:       msk = ENTRY_W'((1 << $urandom_range(0, 8)) - 1);
                1:       msk = ENTRY_W'($urandom_range(0, 255));
                2:       msk = 8'hFF;
                default: msk = 8'h0F;
            endcase
            configure(gain, offs, bits, ENTRY_W'($urandom_range(0, 255)), msk);
            for (n = 0; n < 35; n++) begin
                maybe_gap();
                if ($urandom_range(0, 3) == 0) begin
                    put_entry(ENTRY_W'($urandom_range(0, 255)), rand_dither());
                end else begin
                    case ($urandom_range(0, 3))
                        0:       smp = SAMPLE_W'($urandom_range(0, 255));
                        1:       smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        default: smp = SAMPLE_W'($urandom_range(0, 65535));
                    endcase
                    put_pixel(COL_W'($urandom_range(0, 65535)), smp,
                              $urandom_range(0, 3) == 0);
                end
                if (phase == 3 && n == 25) begin
                    drain();
                end
            end
        end

        drain();
        repeat (6) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("ordered_dither_quantizer_test OK");
        end else begin
            $display("ordered_dither_quantizer_test NOT OK");
        end
        $finish;
    end

endmodule
